FILE: src/tsbn_pkg.sv
`timescale 1ns / 1ps
package tsbn_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int ADDR_W      = 16;
   localparam int DIM_W       = 13;
   localparam int COORD_W     = 20;
   localparam int CH_W        = 8;
   localparam int TEXEL_W     = 3 * CH_W;
   localparam int PROD_W      = COORD_W + DIM_W;
   localparam int IDX_W       = PROD_W - FRAC_BITS;
   localparam int WGT_W       = FRAC_BITS + 1;
   localparam int HPROD_W     = CH_W + WGT_W;
   localparam int VPROD_W     = HPROD_W + WGT_W;
   localparam int OUT_W       = 16;
   localparam int OUT_LSB     = 2 * FRAC_BITS - 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CSR_ADDR_W  = 4;

   localparam logic [DIM_W-1:0] MIN_DIM   = DIM_W'(3);
   localparam logic [DIM_W-1:0] RESET_DIM = DIM_W'(256);
   localparam logic [WGT_W-1:0] WGT_ONE   = WGT_W'(1) << FRAC_BITS;
   localparam logic [PROD_W-1:0] HALF     = PROD_W'(1) << (FRAC_BITS - 1);

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
   localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MODE       = 2'd2;

   typedef struct packed {
      logic               cmd;
      logic [15:0]        texel_index;
      logic [CH_W-1:0]    texel_red;
      logic [CH_W-1:0]    texel_green;
      logic [CH_W-1:0]    texel_blue;
      logic [COORD_W-1:0] u_coord;
      logic [COORD_W-1:0] v_coord;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] out_red;
      logic [OUT_W-1:0] out_green;
      logic [OUT_W-1:0] out_blue;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             bilinear;
   } cfg_type;

   typedef struct packed {
      logic                 is_load;
      logic                 bilinear;
      logic [ADDR_W-1:0]    addr;
      logic [DIM_W-1:0]     row_step;
      logic [TEXEL_W-1:0]   texel;
      logic [FRAC_BITS-1:0] frac_u;
      logic [FRAC_BITS-1:0] frac_v;
   } op_type;

   typedef struct packed {
      logic [WGT_W-1:0] hw;
      logic [WGT_W-1:0] vw;
      logic             row_first;
      logic             row_last;
      logic             col_first;
      logic             col_last;
   } tap_type;

   // Three restoring steps of a modulo by d, shifts top, top-1, top-2.
   function automatic logic [IDX_W-1:0] wrap_part(input logic [IDX_W-1:0] r,
                                                  input logic [DIM_W-1:0] d,
                                                  input logic [2:0] top);
      logic [IDX_W+5:0] acc;
      logic [IDX_W+5:0] sub;
      acc = {6'd0, r};
      for (int s = 0; s < 3; s++) begin
         sub = {{(IDX_W + 6 - DIM_W){1'b0}}, d} << (top - 3'(s));
         if (acc >= sub) begin
            acc = acc - sub;
         end
      end
      return acc[IDX_W-1:0];
   endfunction

endpackage

FILE: src/tsbn_front.sv
`timescale 1ns / 1ps
module tsbn_front import tsbn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   input  cfg_type cfg,
   output logic    push,
   output op_type  push_data,
   input  logic    full
);

   logic                 advance;
   logic                 f1_valid_ff, f2_valid_ff, f3_valid_ff, f4_valid_ff;
   req_type              f1_req_ff, f2_req_ff, f3_req_ff, f4_req_ff;
   logic                 f2_bil_ff, f3_bil_ff, f4_bil_ff;
   logic [PROD_W-1:0]    x_ff, y_ff, x_in, y_in;
   logic [PROD_W-1:0]    xr, yr;
   logic [IDX_W-1:0]     ix, iy;
   logic [IDX_W-1:0]     col3_ff, row3_ff, col3_in, row3_in;
   logic                 wrapx_ff, wrapy_ff, wrapx_in, wrapy_in;
   logic [FRAC_BITS-1:0] fu3_ff, fv3_ff, fu4_ff, fv4_ff;
   logic [DIM_W-1:0]     col4_ff, row4_ff, col4_in, row4_in;
   logic [DIM_W-1:0]     wm1, hm1, wm2, hm2;
   logic [2*DIM_W:0]     lin;

   assign advance = !(f4_valid_ff && full);
   assign busy    = !advance;
   assign push    = f4_valid_ff && !full;

   assign wm1 = cfg.width - DIM_W'(1);
   assign hm1 = cfg.height - DIM_W'(1);
   assign wm2 = cfg.width - DIM_W'(2);
   assign hm2 = cfg.height - DIM_W'(2);

   // scale
   assign x_in = PROD_W'(f1_req_ff.u_coord) * PROD_W'(wm1);
   assign y_in = PROD_W'(f1_req_ff.v_coord) * PROD_W'(hm1);

   // round or floor, then first half of the wrap
   always_comb begin
      xr = f2_bil_ff ? x_ff : x_ff + HALF;
      yr = f2_bil_ff ? y_ff : y_ff + HALF;
      ix = xr[FRAC_BITS +: IDX_W];
      iy = yr[FRAC_BITS +: IDX_W];
      wrapx_in = ix > IDX_W'(wm2);
      wrapy_in = iy > IDX_W'(hm2);
      col3_in = wrapx_in ? wrap_part(ix, wm2, 3'd5) : ix;
      row3_in = wrapy_in ? wrap_part(iy, hm2, 3'd5) : iy;
   end

   // second half of the wrap
   assign col4_in = DIM_W'(wrapx_ff ? wrap_part(col3_ff, wm2, 3'd2) : col3_ff);
   assign row4_in = DIM_W'(wrapy_ff ? wrap_part(row3_ff, hm2, 3'd2) : row3_ff);

   assign lin = (2*DIM_W+1)'(cfg.width) * (2*DIM_W+1)'(row4_ff) + (2*DIM_W+1)'(col4_ff);

   always_comb begin
      push_data.is_load  = f4_req_ff.cmd == CMD_LOAD;
      push_data.bilinear = f4_bil_ff;
      push_data.addr     = (f4_req_ff.cmd == CMD_LOAD) ? f4_req_ff.texel_index
                                                        : lin[ADDR_W-1:0];
      push_data.row_step = cfg.width;
      push_data.texel    = {f4_req_ff.texel_red, f4_req_ff.texel_green,
                            f4_req_ff.texel_blue};
      push_data.frac_u   = fu4_ff;
      push_data.frac_v   = fv4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= start;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_req_ff <= req_data;
         f2_req_ff <= f1_req_ff;
         f2_bil_ff <= cfg.bilinear;
         x_ff      <= x_in;
         y_ff      <= y_in;
         f3_req_ff <= f2_req_ff;
         f3_bil_ff <= f2_bil_ff;
         col3_ff   <= col3_in;
         row3_ff   <= row3_in;
         wrapx_ff  <= wrapx_in;
         wrapy_ff  <= wrapy_in;
         fu3_ff    <= x_ff[FRAC_BITS-1:0];
         fv3_ff    <= y_ff[FRAC_BITS-1:0];
         f4_req_ff <= f3_req_ff;
         f4_bil_ff <= f3_bil_ff;
         col4_ff   <= col4_in;
         row4_ff   <= row4_in;
         fu4_ff    <= fu3_ff;
         fv4_ff    <= fv3_ff;
      end
   end

endmodule

FILE: src/tsbn_queue.sv
`timescale 1ns / 1ps
module tsbn_queue import tsbn_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_data,
   output logic   full,
   input  logic   pop,
   output logic   head_valid,
   output op_type head
);

   op_type              q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full       = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = q_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

endmodule

FILE: src/tsbn_back.sv
`timescale 1ns / 1ps
module tsbn_back import tsbn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  op_type  head,
   output logic    pop,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic [TEXEL_W-1:0]  mem [2**ADDR_W];
   logic [1:0]          tap_ff, tap_in;
   logic                we, re;
   logic [ADDR_W-1:0]   addr;
   logic [WGT_W-1:0]    fu, fv;
   tap_type             ctl;
   logic [TEXEL_W-1:0]  rd_ff;
   logic                p0_valid_ff, p1_valid_ff, p2_valid_ff, p3_valid_ff;
   tap_type             p0_ctl_ff, p1_ctl_ff, p2_ctl_ff, p3_ctl_ff;
   logic [HPROD_W-1:0]  hprod_in [3];
   logic [HPROD_W-1:0]  hprod_ff [3];
   logic [HPROD_W-1:0]  row_in [3];
   logic [HPROD_W-1:0]  row_ff [3];
   logic [VPROD_W-1:0]  vprod_ff [3];
   logic [VPROD_W-1:0]  acc_in [3];
   logic [VPROD_W-1:0]  acc_ff [3];
   logic                rsp_valid_ff;

   assign fu = WGT_W'(head.frac_u);
   assign fv = WGT_W'(head.frac_v);

   // issue one memory access per cycle while an item waits at the queue head
   always_comb begin
      we     = 1'b0;
      re     = 1'b0;
      pop    = 1'b0;
      tap_in = tap_ff;
      addr   = head.addr;
      ctl    = '{hw: WGT_ONE, vw: WGT_ONE, row_first: 1'b1, row_last: 1'b1,
                 col_first: 1'b1, col_last: 1'b1};
      if (head_valid) begin
         if (head.is_load) begin
            we  = 1'b1;
            pop = 1'b1;
         end else if (!head.bilinear) begin
            re  = 1'b1;
            pop = 1'b1;
         end else begin
            re     = 1'b1;
            tap_in = tap_ff + 1'b1;
            pop    = tap_ff == 2'd3;
            ctl.hw        = tap_ff[0] ? fu : WGT_ONE - fu;
            ctl.vw        = tap_ff[1] ? fv : WGT_ONE - fv;
            ctl.row_first = !tap_ff[0];
            ctl.row_last  = tap_ff[0];
            ctl.col_first = !tap_ff[1];
            ctl.col_last  = tap_ff[1];
            case (tap_ff)
               2'd0:    addr = head.addr;
               2'd1:    addr = head.addr + ADDR_W'(1);
               2'd2:    addr = head.addr + ADDR_W'(head.row_step);
               2'd3:    addr = head.addr + ADDR_W'(head.row_step) + ADDR_W'(1);
               default: addr = head.addr;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= head.texel;
      end else if (re) begin
         rd_ff <= mem[addr];
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         hprod_in[c] = HPROD_W'(rd_ff[(2-c)*CH_W +: CH_W]) * HPROD_W'(p0_ctl_ff.hw);
         row_in[c]   = p1_ctl_ff.row_first ? hprod_ff[c] : row_ff[c] + hprod_ff[c];
         acc_in[c]   = p3_ctl_ff.col_first ? vprod_ff[c] : acc_ff[c] + vprod_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff       <= '0;
         p0_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tap_ff       <= tap_in;
         p0_valid_ff  <= re;
         p1_valid_ff  <= p0_valid_ff;
         p2_valid_ff  <= p1_valid_ff && p1_ctl_ff.row_last;
         p3_valid_ff  <= p2_valid_ff;
         rsp_valid_ff <= p3_valid_ff && p3_ctl_ff.col_last;
      end
   end

   always_ff @(posedge clock) begin
      p0_ctl_ff <= ctl;
      p1_ctl_ff <= p0_ctl_ff;
      for (int c = 0; c < 3; c++) begin
         hprod_ff[c] <= hprod_in[c];
      end
      if (p1_valid_ff) begin
         p2_ctl_ff <= p1_ctl_ff;
         for (int c = 0; c < 3; c++) begin
            row_ff[c] <= row_in[c];
         end
      end
      // carry the column flags along with the weighted row sum
      if (p2_valid_ff) begin
         p3_ctl_ff <= p2_ctl_ff;
      end
      for (int c = 0; c < 3; c++) begin
         vprod_ff[c] <= VPROD_W'(row_ff[c]) * VPROD_W'(p2_ctl_ff.vw);
      end
      if (p3_valid_ff) begin
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= acc_in[c];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data.out_red   = acc_ff[0][OUT_LSB +: OUT_W];
   assign rsp_data.out_green = acc_ff[1][OUT_LSB +: OUT_W];
   assign rsp_data.out_blue  = acc_ff[2][OUT_LSB +: OUT_W];

   a_tap_on_bilinear: assert property (@(posedge clock) disable iff (reset)
      (tap_ff != 2'd0) |-> (head_valid && !head.is_load && head.bilinear))
      else $error("tap walk without a bilinear sample at the head");
   a_row_from_read: assert property (@(posedge clock) disable iff (reset)
      p2_valid_ff |-> $past(p0_valid_ff, 2))
      else $error("row sum without texel reads");

endmodule

FILE: src/texture_sampler_bilinear_nearest.sv
`timescale 1ns / 1ps
// Texture sampler with nearest and bilinear filtering.
// Input channel: an item is taken when start is high and busy is low. A load
// item (cmd 0) writes one RGB texel at texel_index; a sample item (cmd 1)
// looks up u,v (16 fraction bits) scaled by width-1 and height-1.
// Result channel: one item per sample on rsp_data, marked by rsp_valid for
// exactly one cycle. The receiver cannot stall; results are never held.
// Loads give no result.
// A sample's result comes after the front stages, any wait in the four-entry
// queue between front and back, and the back's read and blend stages.
// Throughput: the front takes one item per cycle while busy is low. The
// back owns the single-port texel memory: a load or nearest sample makes
// one access, a bilinear sample four reads (one per neighbor) before the
// next item starts. busy rises only when the queue is full.
// Reset clears control state and config (256 x 256, nearest). Texel memory
// is not cleared: sample only texels that were loaded.
// Config via csr port, register i at byte address 4*i; write only while idle.
module texture_sampler_bilinear_nearest import tsbn_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [DIM_W-1:0] tex_width_ff, tex_height_ff;
   logic             bilinear_mode_ff;
   logic             csr_write;
   cfg_type          cfg;
   logic             push, full, pop, head_valid;
   op_type           push_data, head;

   // config registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff     <= RESET_DIM;
         tex_height_ff    <= RESET_DIM;
         bilinear_mode_ff <= 1'b0;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_TEX_WIDTH:  tex_width_ff     <= pwdata[DIM_W-1:0];
            REG_TEX_HEIGHT: tex_height_ff    <= pwdata[DIM_W-1:0];
            REG_MODE:       bilinear_mode_ff <= pwdata[0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_TEX_WIDTH:  prdata = 32'(tex_width_ff);
         REG_TEX_HEIGHT: prdata = 32'(tex_height_ff);
         REG_MODE:       prdata = 32'(bilinear_mode_ff);
         default:        prdata = '0;
      endcase
   end

   // clamp sizes below three up to three
   assign cfg.width    = (tex_width_ff < MIN_DIM) ? MIN_DIM : tex_width_ff;
   assign cfg.height   = (tex_height_ff < MIN_DIM) ? MIN_DIM : tex_height_ff;
   assign cfg.bilinear = bilinear_mode_ff;

   // front: scale, round or floor, wrap, form the linear address
   tsbn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cfg       (cfg),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   // hold decoded items between front and back
   tsbn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // back: texel memory access and blend
   tsbn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: tb/sv/texture_sampler_bilinear_nearest_tb.sv
`timescale 1ns / 1ps
module texture_sampler_bilinear_nearest_tb;
   import tsbn_pkg::*;

   localparam int NTEXELS    = 65536;
   localparam int CYCLE_CAP  = 600000;
   localparam int SETTLE     = 60;

   // Sampler predictor: keeps its own texel store and register copy and
   // lines up the expected colors in acceptance order.
   class texel_scoreboard;
      bit [23:0] texels [NTEXELS];
      bit        loaded [NTEXELS];
      bit [12:0] width_reg  = 13'd256;
      bit [12:0] height_reg = 13'd256;
      bit        blend      = 1'b0;
      rsp_type   colors_due [$];
      int        mismatches = 0;

      function longint unsigned clamp_dim(bit [12:0] s);
         return (s < 3) ? 3 : longint'(s);
      endfunction

      function longint unsigned wrap(longint unsigned i, longint unsigned s);
         return (i > s - 2) ? i % (s - 2) : i;
      endfunction

      // Work out the four texel addresses (only the first in nearest mode)
      // and the fractional weights of a sample.
      function void locate(req_type r, output int unsigned addr [4],
                           output longint unsigned a, output longint unsigned b);
         longint unsigned w, h, x, y, col, row;
         w = clamp_dim(width_reg);
         h = clamp_dim(height_reg);
         x = longint'(r.u_coord) * (w - 1);
         y = longint'(r.v_coord) * (h - 1);
         a = x & 64'hFFFF;
         b = y & 64'hFFFF;
         if (!blend) begin
            col = wrap((x + 64'h8000) >> FRAC_BITS, w);
            row = wrap((y + 64'h8000) >> FRAC_BITS, h);
         end else begin
            col = wrap(x >> FRAC_BITS, w);
            row = wrap(y >> FRAC_BITS, h);
         end
         for (int n = 0; n < 4; n++)
            addr[n] = int'((w * (row + n / 2) + col + n % 2) % NTEXELS);
         if (!blend)
            for (int n = 1; n < 4; n++) addr[n] = addr[0];
      endfunction

      function void note_item(req_type r);
         int unsigned     addr [4];
         longint unsigned a, b, one, acc;
         longint unsigned wt [4];
         rsp_type         c;
         if (r.cmd == CMD_LOAD) begin
            texels[r.texel_index] = {r.texel_red, r.texel_green, r.texel_blue};
            loaded[r.texel_index] = 1'b1;
            return;
         end
         locate(r, addr, a, b);
         if (!blend) begin
            c.out_red   = {texels[addr[0]][23:16], 8'h00};
            c.out_green = {texels[addr[0]][15:8], 8'h00};
            c.out_blue  = {texels[addr[0]][7:0], 8'h00};
         end else begin
            one = 64'h10000;
            wt[0] = (one - a) * (one - b);
            wt[1] = a * (one - b);
            wt[2] = (one - a) * b;
            wt[3] = a * b;
            for (int k = 0; k < 3; k++) begin
               acc = 0;
               for (int n = 0; n < 4; n++)
                  acc += wt[n] * ((texels[addr[n]] >> (16 - 8 * k)) & 64'hFF);
               acc = (acc >> OUT_LSB) & 64'hFFFF;
               if (k == 0) c.out_red = acc[15:0];
               else if (k == 1) c.out_green = acc[15:0];
               else c.out_blue = acc[15:0];
            end
         end
         colors_due = {colors_due, c};
      endfunction

      function void check_color(rsp_type got);
         rsp_type want;
         if (colors_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected color r=%h g=%h b=%h",
                        got.out_red, got.out_green, got.out_blue);
            return;
         end
         want = colors_due.pop_front();
         if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
             got.out_blue !== want.out_blue) begin
            mismatches++;
            if (mismatches <= 10)
               $display("color mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                        want.out_red, want.out_green, want.out_blue,
                        got.out_red, got.out_green, got.out_blue);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   texel_scoreboard sb = new();
   int  cycles   = 0;
   bit  gaps_on  = 1'b1;

   texture_sampler_bilinear_nearest DUT (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Results cannot be held off: check every strobed color at its edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_color(rsp_data);
      end
   end

   // Push one item: optional idle burst, then hold start until busy is low
   // at an edge. Always called right after a rising edge.
   task automatic push_item(req_type r);
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_item(r);
   endtask

   task automatic load_texel(int unsigned idx, bit [23:0] rgb);
      req_type r;
      r = '{cmd: CMD_LOAD, texel_index: idx[15:0], texel_red: rgb[23:16],
            texel_green: rgb[15:8], texel_blue: rgb[7:0],
            u_coord: 20'($urandom()), v_coord: 20'($urandom())};
      push_item(r);
   endtask

   // Load whatever texels the sample would touch that were never written,
   // then send the sample itself.
   task automatic sample_at(bit [19:0] u, bit [19:0] v);
      req_type         r;
      int unsigned     addr [4];
      longint unsigned a, b;
      r = '{cmd: CMD_SAMPLE, texel_index: 16'($urandom()), texel_red: 8'($urandom()),
            texel_green: 8'($urandom()), texel_blue: 8'($urandom()),
            u_coord: u, v_coord: v};
      sb.locate(r, addr, a, b);
      for (int n = 0; n < 4; n++)
         if (!sb.loaded[addr[n]]) load_texel(addr[n], 24'($urandom()));
      push_item(r);
   endtask

   task automatic csr_write(logic [1:0] idx, bit [31:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_TEX_WIDTH) sb.width_reg = value[12:0];
      else if (idx == REG_TEX_HEIGHT) sb.height_reg = value[12:0];
      else sb.blend = value[0];
      @(posedge clock);
   endtask

   // Wait out every pending color, then the tail of any trailing loads.
   task automatic drain();
      start <= 1'b0;
      while (sb.colors_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(bit [12:0] w, bit [12:0] h, bit m);
      drain();
      csr_write(REG_TEX_WIDTH, {3'($urandom_range(0, 7)), 16'd0, w});
      csr_write(REG_TEX_HEIGHT, 32'(h));
      csr_write(REG_MODE, 32'(m));
   endtask

   function automatic bit [19:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 20'd0;
         1: return 20'h10000;
         2: return 20'hFFFFF;
         3: return 20'($urandom_range(0, 20'h1FFFF));
         default: return 20'($urandom_range(0, 20'h10000));
      endcase
   endfunction

   task automatic random_run(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 4) == 0)
            load_texel($urandom_range(0, NTEXELS - 1), 24'($urandom()));
         else
            sample_at(pick_coord(), pick_coord());
      end
   endtask

   bit [12:0] dims_w [7] = '{13'd3, 13'd4096, 13'd0, 13'd8191, 13'd5, 13'd256, 13'd17};
   bit [12:0] dims_h [7] = '{13'd3, 13'd4096, 13'd1, 13'd3, 13'd7, 13'd256, 13'd4096};
   bit        modes  [7] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

   initial begin
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      paddr    <= '0;
      pwdata   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme texel values and addresses under the reset config.
      load_texel(0, 24'h000000);
      load_texel(NTEXELS - 1, 24'hFFFFFF);
      load_texel(1, 24'hFF00FF);
      load_texel(257, 24'h00FF00);
      sample_at(20'd0, 20'd0);
      sample_at(20'h8000, 20'h8000);
      sample_at(20'h7FFF, 20'h10000);
      sample_at(20'h10000, 20'h10000);
      sample_at(20'hFFFFF, 20'hFFFFF);
      random_run(16);

      // Walk the register settings; the last two passes let the block run flat out.
      for (int p = 0; p < 8; p++) begin
         if (p < 7) configure(dims_w[p], dims_h[p], modes[p]);
         else configure(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                        1'($urandom_range(0, 1)));
         if (p == 6) gaps_on = 1'b0;
         sample_at(20'd0, 20'd0);
         sample_at(20'hFFFFF, 20'h0);
         sample_at(20'h8000, 20'hFFFFF);
         sample_at(20'h10000, 20'h10000);
         random_run(28);
      end

      drain();
      if (sb.mismatches == 0 && sb.colors_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
